>>> design/replica_pick_block_grouper_unit_assert.svh
// Assertion macros for the replica picker and block grouper.
// Included by the top level; no other dependencies.
`ifndef REPLICA_PICK_BLOCK_GROUPER_UNIT_ASSERT_SVH
`define REPLICA_PICK_BLOCK_GROUPER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define RPBG_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rpbg check failed");
`define RPBG_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("rpbg forbidden condition");
`else
`define RPBG_ASSERT(lbl, clk, rst, prop)
`define RPBG_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> design/rpbg_pkg.sv
// Shared types and constants of the replica picker and block grouper.
// No dependencies.
`timescale 1ns / 1ps
package rpbg_pkg;
   localparam int NODE_W = 4;
   localparam int SLOT_W = 4;
   localparam int ADDR_W = NODE_W + SLOT_W;
   localparam int NODES = 16;
   localparam int GROUPS = 16;
   localparam int SW = 60;
   localparam int QW = 37;
   localparam logic [4:0] NODES_C = 5'd16;
   localparam logic [4:0] GROUPS_C = 5'd16;
   localparam logic signed [SW-1:0] ONE_Q33 = 60'sd8589934592;
   localparam logic [20:0] USED_MAX = 21'h1FFFFF;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_PLACE = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_RSVD  = 2'd3;

   localparam logic [1:0] CSR_ALPHA = 2'd0;
   localparam logic [1:0] CSR_TOTAL = 2'd1;
   localparam logic [1:0] CSR_MINSZ = 2'd2;
   localparam logic [1:0] CSR_NODES = 2'd3;

   typedef struct packed {
      logic accept;
      logic div_init;
      logic div_step;
      logic mul;
      logic sum;
      logic cmp;
      logic pick;
      logic chk;
      logic scan_rd;
      logic scan_cmp;
      logic fin_rd;
      logic fin_wr;
   } cmd_type;

   typedef struct packed {
      logic place_ok;
      logic div_done;
      logic last_cand;
      logic pick_open;
      logic pick_last;
      logic scan_last;
   } status_type;
endpackage

>>> design/rpbg_ctrl.sv
// Sequencer for the replica picker: scores three candidates, then places the chunk.
// Depends on rpbg_pkg for command and status structs.
`timescale 1ns / 1ps
module rpbg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  rpbg_pkg::status_type sts,
   output rpbg_pkg::cmd_type  cmd
);
   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_DINIT = 11'b00000000010,
      S_DIV  = 11'b00000000100,
      S_MUL  = 11'b00000001000,
      S_SUM  = 11'b00000010000,
      S_CMP  = 11'b00000100000,
      S_PICK = 11'b00001000000,
      S_CHK  = 11'b00010000000,
      S_SRD  = 11'b00100000000,
      S_SCMP = 11'b01000000000,
      S_FIN  = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   logic      fin_wr_ff, fin_wr_in;

   assign busy = (state_ff != S_IDLE) || fin_wr_ff;

   always_comb begin
      state_in = state_ff;
      fin_wr_in = 1'b0;
      cmd = '0;
      if (fin_wr_ff) begin
         cmd.fin_wr = 1'b1;
      end
      case (state_ff)
         S_IDLE: begin
            if (start && !fin_wr_ff) begin
               cmd.accept = 1'b1;
               if (sts.place_ok) state_in = S_DINIT;
            end
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp = 1'b1;
            state_in = sts.last_cand ? S_PICK : S_DINIT;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            if (sts.pick_open) state_in = S_FIN;
            else if (sts.pick_last) state_in = S_CHK;
            else state_in = S_SRD;
         end
         S_CHK: begin
            cmd.chk = 1'b1;
            state_in = S_FIN;
         end
         S_SRD: begin
            cmd.scan_rd = 1'b1;
            state_in = S_SCMP;
         end
         S_SCMP: begin
            cmd.scan_cmp = 1'b1;
            state_in = sts.scan_last ? S_FIN : S_SRD;
         end
         S_FIN: begin
            // read both group memories, write back next cycle
            cmd.fin_rd = 1'b1;
            fin_wr_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fin_wr_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fin_wr_ff <= fin_wr_in;
      end
   end
endmodule

>>> design/rpbg_dpath.sv
// Datapath: node tables, config registers, divider, score unit, group memories.
// Depends on rpbg_pkg; driven by rpbg_ctrl commands.
`timescale 1ns / 1ps
module rpbg_dpath (
   input  logic               clock,
   input  logic               reset,
   input  rpbg_pkg::cmd_type  cmd,
   output rpbg_pkg::status_type sts,
   input  logic [1:0]         req_opcode,
   input  logic [3:0]         req_node_index,
   input  logic [16:0]        req_io_load,
   input  logic [4:0]         req_cpu_count,
   input  logic [39:0]        req_chunk_size,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [39:0]        csr_wdata,
   output logic               rsp_valid,
   output logic [3:0]         rsp_chosen_node,
   output logic [3:0]         rsp_group_slot,
   output logic [15:0]        rsp_group_seq,
   output logic               rsp_opened_group,
   output logic [47:0]        rsp_group_fill
);
   localparam int NW = rpbg_pkg::NODE_W;
   localparam int SW = rpbg_pkg::SW;
   localparam int QW = rpbg_pkg::QW;

   logic [16:0] alpha_ff;
   logic [20:0] total_ff;
   logic [39:0] minsz_ff;
   logic [4:0]  nnodes_ff;

   logic [16:0] io_ff [rpbg_pkg::NODES];
   logic [4:0]  cpu_ff [rpbg_pkg::NODES];
   logic [20:0] used_ff [rpbg_pkg::NODES];
   logic [4:0]  gcount_ff [rpbg_pkg::NODES];
   logic [15:0] gctr_ff;

   logic [NW-1:0] cand_ff [3];
   logic [1:0]    k_ff;
   logic [39:0]   size_ff;
   logic [NW-1:0] win_ff;
   logic signed [SW-1:0] best_ff, score_ff;

   logic [QW-1:0] quo_ff;
   logic [20:0]   rem_ff;
   logic [5:0]    dcnt_ff;

   logic [33:0]          p1_ff;
   logic signed [36:0]   p2_ff;
   logic signed [55:0]   p3_ff;

   logic [rpbg_pkg::SLOT_W-1:0] slot_ff, sidx_ff;
   logic        open_ff;
   logic [47:0] min_ff;

   logic [47:0] fill_mem [1 << rpbg_pkg::ADDR_W];
   logic [15:0] seq_mem [1 << rpbg_pkg::ADDR_W];
   logic [47:0] fill_rd_ff;
   logic [15:0] seq_rd_ff;

   // node count and ring neighbors
   logic [4:0]    nodes_eff;
   logic [NW-1:0] prev_node, next_node;
   logic [20:0]   tot_eff;
   assign nodes_eff = (nnodes_ff == 5'd0) ? 5'd1 :
                      (nnodes_ff > rpbg_pkg::NODES_C) ? rpbg_pkg::NODES_C : nnodes_ff;
   assign prev_node = (req_node_index == '0) ? NW'(nodes_eff - 5'd1) : req_node_index - 4'd1;
   assign next_node = (({1'b0, req_node_index} + 5'd1) >= nodes_eff) ? '0
                      : req_node_index + 4'd1;
   assign tot_eff = (total_ff == '0) ? 21'd1 : total_ff;

   logic use_win;
   logic [NW-1:0] cur, tnode;
   assign use_win = cmd.pick | cmd.chk | cmd.scan_rd | cmd.scan_cmp | cmd.fin_rd | cmd.fin_wr;
   assign cur = cand_ff[k_ff];
   assign tnode = use_win ? win_ff : cur;

   logic [16:0] io_sel;
   logic [4:0]  cpu_sel, g_sel;
   logic [20:0] used_sel;
   assign io_sel = io_ff[tnode];
   assign cpu_sel = cpu_ff[tnode];
   assign used_sel = used_ff[tnode];
   assign g_sel = gcount_ff[tnode];

   assign sts.place_ok = (req_opcode == rpbg_pkg::OP_PLACE) &&
                         ({1'b0, req_node_index} < nodes_eff);
   assign sts.div_done = (dcnt_ff == 6'(QW - 1));
   assign sts.last_cand = (k_ff == 2'd2);
   assign sts.pick_open = (g_sel == 5'd0);
   assign sts.pick_last = (g_sel < cpu_sel) && (g_sel < rpbg_pkg::GROUPS_C);
   assign sts.scan_last = (({1'b0, sidx_ff} + 5'd1) == g_sel);

   // restoring divider step
   logic [21:0] rem_sh;
   logic        qbit;
   assign rem_sh = {rem_ff, quo_ff[QW-1]};
   assign qbit = rem_sh >= {1'b0, tot_eff};

   // score terms
   logic signed [17:0] wa;
   logic signed [18:0] cp;
   logic signed [SW-1:0] t1, t2, t3, tc;
   assign wa = 18'sd65536 - $signed({1'b0, alpha_ff});
   assign cp = 19'sd65536 - $signed({1'b0, cpu_sel, 13'd0});
   assign t1 = $signed(SW'({1'b0, p1_ff}));
   assign t2 = SW'(p2_ff);
   assign t3 = SW'(p3_ff) <<< 1;
   assign tc = (cpu_sel == 5'd0) ? rpbg_pkg::ONE_Q33 : '0;

   // memory addressing
   logic [rpbg_pkg::ADDR_W-1:0] raddr, waddr;
   logic [rpbg_pkg::SLOT_W-1:0] glast;
   assign glast = rpbg_pkg::SLOT_W'(g_sel - 5'd1);
   assign raddr = cmd.scan_rd ? {win_ff, sidx_ff} :
                  cmd.fin_rd  ? {win_ff, slot_ff} : {win_ff, glast};
   assign waddr = {win_ff, slot_ff};

   logic [47:0] old_fill, fill_new;
   logic [48:0] fill_sum;
   assign old_fill = open_ff ? '0 : fill_rd_ff;
   assign fill_sum = {1'b0, old_fill} + {9'd0, size_ff};
   assign fill_new = fill_sum[48] ? '1 : fill_sum[47:0];

   always_ff @(posedge clock) begin
      if (cmd.fin_wr) fill_mem[waddr] <= fill_new;
      fill_rd_ff <= fill_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_wr && open_ff) seq_mem[waddr] <= gctr_ff;
      seq_rd_ff <= seq_mem[raddr];
   end

   // configuration and architectural tables
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 17'd32768;
         total_ff <= 21'd1;
         minsz_ff <= 40'd33554432;
         nnodes_ff <= 5'd16;
         gctr_ff <= '0;
         for (int i = 0; i < rpbg_pkg::NODES; i++) begin
            io_ff[i] <= '0;
            cpu_ff[i] <= '0;
            used_ff[i] <= '0;
            gcount_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               rpbg_pkg::CSR_ALPHA: alpha_ff <= csr_wdata[16:0];
               rpbg_pkg::CSR_TOTAL: total_ff <= csr_wdata[20:0];
               rpbg_pkg::CSR_MINSZ: minsz_ff <= csr_wdata;
               rpbg_pkg::CSR_NODES: nnodes_ff <= csr_wdata[4:0];
               default: ;
            endcase
         end
         if (cmd.accept && req_opcode == rpbg_pkg::OP_LOAD) begin
            io_ff[req_node_index] <= req_io_load;
            cpu_ff[req_node_index] <= req_cpu_count;
         end
         if (cmd.accept && req_opcode == rpbg_pkg::OP_CLEAR) begin
            gctr_ff <= '0;
            for (int i = 0; i < rpbg_pkg::NODES; i++) begin
               used_ff[i] <= '0;
               gcount_ff[i] <= '0;
            end
         end
         if (cmd.fin_wr) begin
            if (used_sel != rpbg_pkg::USED_MAX) used_ff[win_ff] <= used_sel + 21'd1;
            if (open_ff) begin
               gctr_ff <= gctr_ff + 16'd1;
               gcount_ff[win_ff] <= g_sel + 5'd1;
            end
         end
      end
   end

   // scoring and placement working registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cand_ff[0] <= prev_node;
         cand_ff[1] <= req_node_index;
         cand_ff[2] <= next_node;
         k_ff <= '0;
         size_ff <= req_chunk_size;
         open_ff <= 1'b0;
      end
      if (cmd.div_init) begin
         quo_ff <= {used_sel, 16'd0};
         rem_ff <= '0;
         dcnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= qbit ? 21'(rem_sh - {1'b0, tot_eff}) : rem_sh[20:0];
         quo_ff <= {quo_ff[QW-2:0], qbit};
         dcnt_ff <= dcnt_ff + 6'd1;
      end
      if (cmd.mul) begin
         p1_ff <= 34'(alpha_ff) * 34'(io_sel);
         p2_ff <= 37'($signed({1'b0, alpha_ff})) * 37'(cp);
         p3_ff <= 56'(wa) * 56'($signed({1'b0, quo_ff}));
      end
      if (cmd.sum) score_ff <= rpbg_pkg::ONE_Q33 - t1 - t2 - t3 - tc;
      if (cmd.cmp) begin
         // first highest wins
         if (k_ff == 2'd0 || score_ff > best_ff) begin
            best_ff <= score_ff;
            win_ff <= cur;
         end
         if (!sts.last_cand) k_ff <= k_ff + 2'd1;
      end
      if (cmd.pick) begin
         sidx_ff <= '0;
         if (sts.pick_open) begin
            open_ff <= 1'b1;
            slot_ff <= '0;
         end
      end
      if (cmd.chk) begin
         if (fill_rd_ff >= {8'd0, minsz_ff}) begin
            open_ff <= 1'b1;
            slot_ff <= rpbg_pkg::SLOT_W'(g_sel);
         end else begin
            slot_ff <= glast;
         end
      end
      if (cmd.scan_cmp) begin
         if (sidx_ff == '0 || fill_rd_ff < min_ff) begin
            min_ff <= fill_rd_ff;
            slot_ff <= sidx_ff;
         end
         sidx_ff <= sidx_ff + rpbg_pkg::SLOT_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.fin_wr;
      end
      if (cmd.fin_wr) begin
         rsp_chosen_node <= win_ff;
         rsp_group_slot <= slot_ff;
         rsp_group_seq <= open_ff ? gctr_ff : seq_rd_ff;
         rsp_opened_group <= open_ff;
         rsp_group_fill <= fill_new;
      end
   end
endmodule

>>> design/replica_pick_block_grouper_unit.sv
// Replica picker and block grouper, top level.
// Load, clear and ignored items are taken without leaving idle. A placement scores three
// nodes in turn (37-step divider), then opens a group, checks the last group or scans
// all groups of the winning node.
// Busy drops in the result cycle; rsp_valid lasts one cycle and cannot be stalled.
// Reset (synchronous, active high) restores config defaults and clears all node tables.
`timescale 1ns / 1ps
`include "replica_pick_block_grouper_unit_assert.svh"
module replica_pick_block_grouper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_node_index,
   input  logic [16:0] req_io_load,
   input  logic [4:0]  req_cpu_count,
   input  logic [39:0] req_chunk_size,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [39:0] csr_wdata,
   output logic        rsp_valid,
   output logic [3:0]  rsp_chosen_node,
   output logic [3:0]  rsp_group_slot,
   output logic [15:0] rsp_group_seq,
   output logic        rsp_opened_group,
   output logic [47:0] rsp_group_fill
);
   rpbg_pkg::cmd_type    cmd;
   rpbg_pkg::status_type sts;

   assign csr_ready = 1'b1;

   rpbg_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .sts(sts),
      .cmd(cmd)
   );

   rpbg_dpath u_dpath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .sts(sts),
      .req_opcode(req_opcode),
      .req_node_index(req_node_index),
      .req_io_load(req_io_load),
      .req_cpu_count(req_cpu_count),
      .req_chunk_size(req_chunk_size),
      .csr_valid(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_chosen_node(rsp_chosen_node),
      .rsp_group_slot(rsp_group_slot),
      .rsp_group_seq(rsp_group_seq),
      .rsp_opened_group(rsp_opened_group),
      .rsp_group_fill(rsp_group_fill)
   );

   `RPBG_NEVER(a_rsp_while_busy, clock, reset, rsp_valid && busy)
   `RPBG_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)
   `RPBG_ASSERT(a_busy_from_start, clock, reset, $rose(busy) |-> $past(start))
endmodule
